// ----- design/tree_lca_binary_lifting_top_defines.svh -----
// Assertion macros shared by the lowest-common-ancestor block.
`ifndef TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TLCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tlca_pkg.sv -----
// Package: command and status codes and sequencer states of the LCA block.
`timescale 1ns / 1ps
package tlca_pkg;

	localparam int CMD_W = 2;
	localparam int STAT_W = 2;
	localparam int ID_W = 10;
	localparam int PAR_W = 11;
	localparam int CNT_W = 11;
	localparam int WIDE_W = 17;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_ANSWER = 2'd0;
	localparam logic [STAT_W-1:0] ST_LOADED = 2'd1;
	localparam logic [STAT_W-1:0] ST_BUILT = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EXEC,
		S_B1_RA,
		S_B1_RM,
		S_B1_WR,
		S_B2_RD,
		S_B2_CK,
		S_Q_DA,
		S_Q_DB,
		S_Q_DW,
		S_Q_L1R,
		S_Q_L1C,
		S_Q_CMP,
		S_Q_L2R,
		S_Q_L2C,
		S_Q_FR,
		S_Q_FC,
		S_RESP
	} state_t;

endpackage

// ----- design/tree_lca_binary_lifting_top.sv -----
// Lowest common ancestor over a rooted tree by binary lifting: top level.
// Use:
//   s_* stream: one beat per command. tuser = cmd (0 load parent, 1 build,
//   2 query); tdata = node [9:0], parent_node [20:10] (-1 = none),
//   other_node [30:21].
//   m_* stream: one beat per command. tuser = status, tdata = ancestor [9:0].
//   cfg_*: writes node_count; always ready, write only while idle.
// Sequence per command, one at a time, up to the result register:
//   load or rejected command: execute state, then response state; the next
//   beat is taken once the sequencer is back in idle.
//   query: two depth reads, lift the deeper node, lift both nodes from the top
//   level down, then a parent read; a single registered read per memory port.
//   build: each level above 0 for every node, then a depth walk per node.
// A finished result waits in the output register; the sequencer holds in
// its response state while the receiver stalls and the register is full,
// and s_tready is high only while the sequencer is idle.
// Reset clears control and sets node_count to 1024. The ancestor and depth
// memories are not cleared: load every node in use and build before a query.
// Node 0 is the root and always reads as having no ancestors.
`timescale 1ns / 1ps
`include "tree_lca_binary_lifting_top_defines.svh"
module tree_lca_binary_lifting_top #(
	parameter int NODES = 1024,
	parameter int LEVELS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // node[9:0], parent_node[20:10], other_node[30:21]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // ancestor[9:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	import tlca_pkg::*;

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AW = IW + LW;
	localparam int EW = IW + 1;
	localparam int DW = LEVELS;
	localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);
	localparam logic [LW-1:0] TOP_LVL = LW'(LEVELS - 1);

	state_t state_q, state_nx;

	logic [CNT_W-1:0]  count_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   in_a_q, in_b_q;
	logic [PAR_W-1:0]  in_p_q;
	logic [IW-1:0]     a_q, b_q, i_q, v_q;
	logic [LW-1:0]     j_q;
	logic [DW-1:0]     d_q, da_q, diff_q;
	logic [IW-1:0]     res_anc_q;
	logic [STAT_W-1:0] res_stat_q;
	logic              m_valid_q;
	logic [STAT_W-1:0] m_stat_q;
	logic [ID_W-1:0]   m_anc_q;

	// memories
	logic [EW-1:0] anc_mem [0:(1 << AW)-1];
	logic [DW-1:0] dep_mem [0:NODES-1];
	logic [AW-1:0] ar0, ar1, aw;
	logic [EW-1:0] awd, ard0_q, ard1_q;
	logic          awe, z0_q, z1_q;
	logic [IW-1:0] dra, dwa;
	logic [DW-1:0] dwd, drd_q;
	logic          dwe;

	always_ff @(posedge clk) begin
		if (awe) begin
			anc_mem[aw] <= awd;
		end
		ard0_q <= anc_mem[ar0];
		ard1_q <= anc_mem[ar1];
		z0_q <= (ar0[AW-1:LW] == '0);
		z1_q <= (ar1[AW-1:LW] == '0);
	end

	always_ff @(posedge clk) begin
		if (dwe) begin
			dep_mem[dwa] <= dwd;
		end
		drd_q <= dep_mem[dra];
	end

	// node 0 never has an ancestor
	logic          vld0, vld1;
	logic [IW-1:0] id0, id1;
	assign vld0 = ard0_q[IW] && !z0_q;
	assign vld1 = ard1_q[IW] && !z1_q;
	assign id0 = ard0_q[IW-1:0];
	assign id1 = ard1_q[IW-1:0];

	// range checks
	logic [WIDE_W-1:0] lim_w, a_w, b_w, p_w, anc_w;
	logic              p_none, bad_load, bad_query;
	logic [IW-1:0]     a_id, b_id, p_id;
	logic [DW-1:0]     d_nx;

	always_comb begin
		lim_w = (WIDE_W'(count_q) < WIDE_W'(NODES)) ? WIDE_W'(count_q) : WIDE_W'(NODES);
		a_w = WIDE_W'(in_a_q);
		b_w = WIDE_W'(in_b_q);
		p_w = WIDE_W'(in_p_q[ID_W-1:0]);
		a_id = a_w[IW-1:0];
		b_id = b_w[IW-1:0];
		p_id = p_w[IW-1:0];
		p_none = (in_p_q == '1);
		bad_load = (a_w >= lim_w) || (!p_none && (in_p_q[PAR_W-1] || p_w >= lim_w));
		bad_query = (a_w >= lim_w) || (b_w >= lim_w);
		d_nx = vld0 ? (d_q + (DW'(1) << j_q)) : d_q;
		anc_w = WIDE_W'(res_anc_q);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_nx = S_EXEC;
			S_EXEC: begin
				priority if (cmd_q == CMD_LOAD) state_nx = S_RESP;
				else if (cmd_q == CMD_BUILD) state_nx = (LEVELS > 1) ? S_B1_RA : S_B2_RD;
				else if (cmd_q == CMD_QUERY) state_nx = bad_query ? S_RESP : S_Q_DA;
				else state_nx = S_RESP;
			end
			S_B1_RA: state_nx = S_B1_RM;
			S_B1_RM, S_B1_WR: begin
				if (state_q == S_B1_RM && vld0) begin
					state_nx = S_B1_WR;
				end else if (i_q == LAST_NODE && j_q == TOP_LVL) begin
					state_nx = S_B2_RD;
				end else begin
					state_nx = S_B1_RA;
				end
			end
			S_B2_RD: state_nx = S_B2_CK;
			S_B2_CK: begin
				if (j_q == '0 && i_q == LAST_NODE) state_nx = S_RESP;
				else state_nx = S_B2_RD;
			end
			S_Q_DA: state_nx = S_Q_DB;
			S_Q_DB: state_nx = S_Q_DW;
			S_Q_DW: state_nx = S_Q_L1R;
			S_Q_L1R: begin
				if (diff_q[j_q]) state_nx = S_Q_L1C;
				else if (j_q == '0) state_nx = S_Q_CMP;
			end
			S_Q_L1C: state_nx = (j_q == '0) ? S_Q_CMP : S_Q_L1R;
			S_Q_CMP: state_nx = (a_q == b_q) ? S_RESP : S_Q_L2R;
			S_Q_L2R: state_nx = S_Q_L2C;
			S_Q_L2C: state_nx = (j_q == '0) ? S_Q_FR : S_Q_L2R;
			S_Q_FR: state_nx = S_Q_FC;
			S_Q_FC: state_nx = S_RESP;
			S_RESP: if (!m_valid_q || m_tready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		ar0 = '0;
		ar1 = '0;
		awe = 1'b0;
		aw = {i_q, j_q};
		awd = '0;
		dra = a_q;
		dwe = 1'b0;
		dwa = i_q;
		dwd = d_nx;
		unique case (state_q)
			S_EXEC: begin
				aw = {a_id, LW'(0)};
				awd = {!p_none, p_none ? IW'(0) : p_id};
				awe = (cmd_q == CMD_LOAD) && !bad_load && (a_id != '0);
			end
			S_B1_RA: ar0 = {i_q, j_q - 1'b1};
			S_B1_RM: begin
				ar0 = {id0, j_q - 1'b1};
				awe = !vld0;
			end
			S_B1_WR: begin
				awd = {vld0, id0};
				awe = 1'b1;
			end
			S_B2_RD: ar0 = {v_q, j_q};
			S_B2_CK: dwe = (j_q == '0);
			S_Q_DA: dra = a_q;
			S_Q_DB: dra = b_q;
			S_Q_L1R: ar0 = {a_q, j_q};
			S_Q_L2R: begin
				ar0 = {a_q, j_q};
				ar1 = {b_q, j_q};
			end
			S_Q_FR: ar0 = {a_q, LW'(0)};
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= COUNT_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) count_q <= cfg_data;
			if (state_q == S_RESP && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!m_valid_q || m_tready)) begin
			m_stat_q <= res_stat_q;
			m_anc_q <= anc_w[ID_W-1:0];
		end
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= s_tuser;
				in_a_q <= s_tdata[9:0];
				in_p_q <= s_tdata[20:10];
				in_b_q <= s_tdata[30:21];
			end
			S_EXEC: begin
				a_q <= a_id;
				b_q <= b_id;
				i_q <= '0;
				v_q <= '0;
				d_q <= '0;
				j_q <= (LEVELS > 1) ? LW'(1) : LW'(0);
				res_anc_q <= '0;
				priority if (cmd_q == CMD_LOAD) res_stat_q <= bad_load ? ST_RANGE : ST_LOADED;
				else if (cmd_q == CMD_BUILD) res_stat_q <= ST_BUILT;
				else if (cmd_q == CMD_QUERY) res_stat_q <= bad_query ? ST_RANGE : ST_ANSWER;
				else res_stat_q <= ST_RANGE;
			end
			S_B1_RM, S_B1_WR: begin
				if (!(state_q == S_B1_RM && vld0)) begin
					if (i_q == LAST_NODE) begin
						i_q <= '0;
						if (j_q == TOP_LVL) begin
							v_q <= '0;
							d_q <= '0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			S_B2_CK: begin
				if (j_q == '0) begin
					i_q <= i_q + 1'b1;
					v_q <= i_q + 1'b1;
					d_q <= '0;
					j_q <= TOP_LVL;
				end else begin
					if (vld0) v_q <= id0;
					d_q <= d_nx;
					j_q <= j_q - 1'b1;
				end
			end
			S_Q_DB: da_q <= drd_q;
			S_Q_DW: begin
				j_q <= TOP_LVL;
				if (da_q < drd_q) begin
					a_q <= b_q;
					b_q <= a_q;
					diff_q <= drd_q - da_q;
				end else begin
					diff_q <= da_q - drd_q;
				end
			end
			S_Q_L1R: if (!diff_q[j_q] && j_q != '0) j_q <= j_q - 1'b1;
			S_Q_L1C: begin
				if (vld0) a_q <= id0;
				if (j_q != '0) j_q <= j_q - 1'b1;
			end
			S_Q_CMP: begin
				res_anc_q <= a_q;
				j_q <= TOP_LVL;
			end
			S_Q_L2C: begin
				if (vld0 && vld1 && id0 != id1) begin
					a_q <= id0;
					b_q <= id1;
				end
				if (j_q != '0) j_q <= j_q - 1'b1;
			end
			S_Q_FC: res_anc_q <= vld0 ? id0 : '0;
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_valid_q;
	assign m_tuser = m_stat_q;
	assign m_tdata = {6'd0, m_anc_q};

	`TLCA_ASSERT_NEXT(a_accept_exec, clk, arst_n, s_tvalid && s_tready, state_q == S_EXEC, "accepted beat not decoded")
	`TLCA_ASSERT_NEXT(a_resp_hold, clk, arst_n, state_q == S_RESP && m_valid_q && !m_tready, state_q == S_RESP, "result dropped while output stalled")
	`TLCA_ASSERT_NOW(a_load_write, clk, arst_n, awe && state_q == S_EXEC, cmd_q == CMD_LOAD && a_id != '0, "table write outside a valid load")

endmodule
